// File: rtl/mse_pkg.sv
// Shared types, constants and code tables for the Morse segment encoder.
// Used by the top, mse_front and mse_back; depends on nothing.
package mse_pkg;

  localparam int DOT_W     = 17;
  localparam int RATIO_W   = 15;
  localparam int SAMPLES_W = 24;
  localparam int MAX_SYMS  = 6;
  localparam int NSYM_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_TYPE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOT_SAMPLES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DASH        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_GAP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_SPACE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_SPACE  = 3'd6;

  localparam logic [RATIO_W-1:0] DOT_RATIO = 15'd256;

  typedef enum logic [2:0] {
    SYM_DOT,
    SYM_DASH,
    SYM_SPC,
    SYM_LONG_L,
    SYM_LONG_ZERO
  } sym_t;

  typedef enum logic [1:0] {
    KIND_SILENCE = 2'd0,
    KIND_MARK    = 2'd1,
    KIND_GAP     = 2'd2
  } seg_kind_t;

  typedef struct packed {
    logic                 code_type;
    logic [DOT_W-1:0]     dot_samples;
    logic [RATIO_W-1:0]   dash_ratio;
    logic [RATIO_W-1:0]   mark_gap_ratio;
    logic [RATIO_W-1:0]   inner_space_ratio;
    logic [RATIO_W-1:0]   char_space_ratio;
    logic [RATIO_W-1:0]   word_space_ratio;
  } cfg_t;

  typedef struct packed {
    logic                  known;
    logic [NSYM_W-1:0]     nsym;
    sym_t [MAX_SYMS-1:0]   syms;
  } code_t;

  typedef struct packed {
    logic                  is_space;
    logic                  lead;
    logic [NSYM_W-1:0]     nsym;
    sym_t [MAX_SYMS-1:0]   syms;
  } job_t;

  typedef struct packed {
    seg_kind_t              kind;
    logic [SAMPLES_W-1:0]   samples;
    logic                   last;
  } seg_t;

  // Codes as up to six ASCII symbols, right-justified and zero-padded.
  localparam logic [47:0] AM_ALPHA [26] = '{
    ".-", "-...", ".. .", "-..", ".", ".-.", "--.", "....", "..", "-.-.",
    "-.-", "L", "--", "-.", ". .", ".....", "..-.", ". ..", "...", "-",
    "..-", "...-", ".--", ".-..", ".. ..", "... ."
  };
  localparam logic [47:0] AM_NUM [10] = '{
    "0", ".--.", "..-..", "...-.", "....-", "---", "......", "--..",
    "-....", "-..-"
  };
  localparam logic [47:0] IT_ALPHA [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  localparam logic [47:0] IT_NUM [10] = '{
    "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
    "---..", "----."
  };

  function automatic sym_t to_sym(input logic [7:0] b);
    sym_t s;
    case (b)
      "-":     s = SYM_DASH;
      " ":     s = SYM_SPC;
      "L":     s = SYM_LONG_L;
      "0":     s = SYM_LONG_ZERO;
      default: s = SYM_DOT;
    endcase
    return s;
  endfunction

  function automatic code_t parse(input logic [47:0] str);
    code_t      c;
    logic [7:0] b;
    c = '0;
    for (int i = MAX_SYMS - 1; i >= 0; i--) begin
      b = str[8*i +: 8];
      if (b != 8'h00) begin
        c.syms[c.nsym] = to_sym(b);
        c.nsym         = c.nsym + 3'd1;
      end
    end
    return c;
  endfunction

  function automatic code_t lookup(input logic intl, input logic [7:0] ch);
    logic [47:0] str;
    logic        hit;
    code_t       c;
    str = '0;
    hit = 1'b1;
    if (!intl) begin
      if (ch inside {["A":"Z"]})      str = AM_ALPHA[5'(ch - "A")];
      else if (ch inside {["a":"z"]}) str = AM_ALPHA[5'(ch - "a")];
      else if (ch inside {["0":"9"]}) str = AM_NUM[4'(ch - "0")];
      else if (ch == ".")             str = "..--..";
      else if (ch == ",")             str = ".-.-";
      else if (ch == "?")             str = "-..-.";
      else                            hit = 1'b0;
    end else begin
      if (ch inside {["A":"Z"]})      str = IT_ALPHA[5'(ch - "A")];
      else if (ch inside {["0":"9"]}) str = IT_NUM[4'(ch - "0")];
      else if (ch == ".")             str = ".-.-.-";
      else if (ch == ",")             str = "--..--";
      else if (ch == "?")             str = "..--..";
      else                            hit = 1'b0;
    end
    c       = parse(str);
    c.known = hit;
    return c;
  endfunction

endpackage

// File: rtl/morse_segment_encoder.sv
// Morse segment encoder: takes ASCII characters, gives timed key segments.
// Pushing a character: in_push with in_char_code and in_starts_message; the
// beat is taken when in_full is low. Segments come out of a queue: while
// out_empty is low the oldest segment is on out_segment_kind,
// out_segment_samples and out_last_segment, and out_pop takes it.
// Registers are written through cfg_we / cfg_index / cfg_data while idle;
// the user must keep to this, the block does not enforce it. With the back
// end idle, an accepted character passes the job queue, the job register,
// the A and B registers and the segment queue before its first segment is
// on the result ports. After a load the back end sends one segment per
// cycle while the queue has room; an unknown first character sends nothing.
// A two-entry job queue lets characters be accepted while the back end runs.
// When the receiver stalls, the four-entry segment queue fills, the sequencer
// holds, then the job queue fills and in_full rises. Nothing is dropped.
// Reset empties both queues and loads the default timing registers
// (American table, 533 samples per dot).
// Depends on mse_pkg, mse_fifo, mse_front and mse_back.
module morse_segment_encoder #(
  parameter int LONG_L_RATIO    = 1434,
  parameter int LONG_ZERO_RATIO = 2278
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_starts_message,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [1:0]                       out_segment_kind,
  output logic [mse_pkg::SAMPLES_W-1:0]    out_segment_samples,
  output logic                             out_last_segment,
  input  logic                             cfg_we,
  input  logic [mse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mse_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int JQ_AW  = 1;
  localparam int OUT_AW = 2;

  mse_pkg::cfg_t  cfg_r;
  logic           job_push, job_pop, jq_empty, jq_full;
  mse_pkg::job_t  job_in, job_out;
  logic [JQ_AW:0] jq_count;
  logic           seg_push, oq_full;
  mse_pkg::seg_t  seg_in, seg_out;
  logic [OUT_AW:0] oq_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_type         <= 1'b0;
      cfg_r.dot_samples       <= 17'd533;
      cfg_r.dash_ratio        <= 15'd768;
      cfg_r.mark_gap_ratio    <= 15'd256;
      cfg_r.inner_space_ratio <= 15'd512;
      cfg_r.char_space_ratio  <= 15'd768;
      cfg_r.word_space_ratio  <= 15'd1792;
    end else if (cfg_we) begin
      case (cfg_index)
        mse_pkg::REG_CODE_TYPE:   cfg_r.code_type         <= cfg_data[0];
        mse_pkg::REG_DOT_SAMPLES: cfg_r.dot_samples       <= cfg_data;
        mse_pkg::REG_DASH:        cfg_r.dash_ratio        <= cfg_data[14:0];
        mse_pkg::REG_MARK_GAP:    cfg_r.mark_gap_ratio    <= cfg_data[14:0];
        mse_pkg::REG_INNER_SPACE: cfg_r.inner_space_ratio <= cfg_data[14:0];
        mse_pkg::REG_CHAR_SPACE:  cfg_r.char_space_ratio  <= cfg_data[14:0];
        mse_pkg::REG_WORD_SPACE:  cfg_r.word_space_ratio  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  mse_front u_front (
    .in_push           (in_push),
    .in_char_code      (in_char_code),
    .in_starts_message (in_starts_message),
    .code_type         (cfg_r.code_type),
    .jq_full           (jq_full),
    .job_push          (job_push),
    .job               (job_in)
  );

  mse_fifo #(
    .WIDTH ($bits(mse_pkg::job_t)),
    .AW    (JQ_AW)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (jq_empty),
    .full  (jq_full),
    .count (jq_count)
  );

  mse_back #(
    .LONG_L_RATIO    (LONG_L_RATIO),
    .LONG_ZERO_RATIO (LONG_ZERO_RATIO),
    .OUT_AW          (OUT_AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (~jq_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_count (oq_count),
    .seg_push  (seg_push),
    .seg       (seg_in)
  );

  mse_fifo #(
    .WIDTH ($bits(mse_pkg::seg_t)),
    .AW    (OUT_AW)
  ) u_seg_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (seg_push),
    .din   (seg_in),
    .pop   (out_pop),
    .dout  (seg_out),
    .empty (out_empty),
    .full  (oq_full),
    .count (oq_count)
  );

  assign in_full             = jq_full;
  assign out_segment_kind    = seg_out.kind;
  assign out_segment_samples = seg_out.samples;
  assign out_last_segment    = seg_out.last;

  // segment credit must keep the output queue from overflowing
  a_seg_room: assert property (@(posedge clk) disable iff (!rst_n)
    seg_push |-> !oq_full)
    else $error("segment beat pushed into a full queue");

  a_job_pop: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (!jq_empty && jq_count != '0))
    else $error("job taken from an empty queue");

  a_job_room: assert property (@(posedge clk) disable iff (!rst_n)
    (jq_full && !job_pop) |=> !job_push)
    else $error("job pushed while the job queue stayed full");

endmodule

// File: rtl/mse_fifo.sv
// Small first-word-fall-through queue in flip-flops.
// Used for the job queue and the segment queue; no package dependency.
module mse_fifo #(
  parameter int WIDTH = 8,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full,
  output logic [AW:0]      count
);

  localparam int DEPTH = 2 ** AW;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    rp_r;
  logic [AW:0]      cnt_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign count   = cnt_r;
  assign dout    = mem_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// File: rtl/mse_front.sv
// Front end: looks the character up and turns it into a job for the back end.
// Depends on mse_pkg (code tables, job_t).
module mse_front (
  input  logic              in_push,
  input  logic [7:0]        in_char_code,
  input  logic              in_starts_message,
  input  logic              code_type,
  input  logic              jq_full,
  output logic              job_push,
  output mse_pkg::job_t     job
);

  mse_pkg::code_t code;
  logic           has_segs;

  always_comb begin
    code         = mse_pkg::lookup(code_type, in_char_code);
    job.is_space = (in_char_code == " ");
    job.lead     = ~in_starts_message;
    job.nsym     = (job.is_space || !code.known) ? '0 : code.nsym;
    job.syms     = code.syms;
    // an unknown first character sends nothing
    has_segs     = job.is_space | job.lead | (job.nsym != '0);
  end

  assign job_push = in_push & ~jq_full & has_segs;

endmodule

// File: rtl/mse_back.sv
// Back end: steps a job one segment per cycle while output has room, then
// scales the ratio by dot_samples. Depends on mse_pkg (cfg_t, job_t, seg_t).
module mse_back #(
  parameter int LONG_L_RATIO    = 1434,
  parameter int LONG_ZERO_RATIO = 2278,
  parameter int OUT_AW          = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mse_pkg::cfg_t     cfg,
  input  logic              job_valid,
  input  mse_pkg::job_t     job,
  output logic              job_pop,
  input  logic [OUT_AW:0]   out_count,
  output logic              seg_push,
  output mse_pkg::seg_t     seg
);

  localparam int OUT_DEPTH = 2 ** OUT_AW;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                              state_r, state_nxt;
  mse_pkg::job_t                       job_r, job_nxt;
  logic                                lead_r, lead_nxt;
  logic [mse_pkg::NSYM_W-1:0]          idx_r, idx_nxt;
  logic                                phase_r, phase_nxt;

  logic                                a_vld_r, a_vld_nxt;
  mse_pkg::seg_kind_t                  a_kind_r, a_kind_nxt;
  logic [mse_pkg::RATIO_W-1:0]         a_ratio_r, a_ratio_nxt;
  logic                                a_last_r, a_last_nxt;

  logic                                b_vld_r;
  mse_pkg::seg_t                       b_seg_r;

  logic [OUT_AW+1:0]                   used;
  logic                                room;
  logic [mse_pkg::RATIO_W+1:0]         d_word, d_char, d_inner, sel;
  logic [mse_pkg::RATIO_W-1:0]         mark_ratio;
  logic                                last_sym;
  mse_pkg::sym_t                       sym;
  logic [mse_pkg::DOT_W+mse_pkg::RATIO_W-1:0] prod;

  // differences of three ratios stay within 17-bit two's complement
  assign d_word  = {2'b00, cfg.word_space_ratio} - {2'b00, cfg.char_space_ratio}
                 - {2'b00, cfg.mark_gap_ratio};
  assign d_char  = {2'b00, cfg.char_space_ratio} - {2'b00, cfg.mark_gap_ratio};
  assign d_inner = {2'b00, cfg.inner_space_ratio} - {2'b00, cfg.mark_gap_ratio};

  assign used = (OUT_AW+2)'(out_count) + (OUT_AW+2)'(a_vld_r) + (OUT_AW+2)'(b_vld_r);
  assign room = used < (OUT_AW+2)'(OUT_DEPTH);

  assign sym      = job_r.syms[idx_r];
  assign last_sym = (3'(idx_r + 3'd1) == job_r.nsym);

  always_comb begin
    case (sym)
      mse_pkg::SYM_DASH:      mark_ratio = cfg.dash_ratio;
      mse_pkg::SYM_LONG_L:    mark_ratio = mse_pkg::RATIO_W'(LONG_L_RATIO);
      mse_pkg::SYM_LONG_ZERO: mark_ratio = mse_pkg::RATIO_W'(LONG_ZERO_RATIO);
      default:                mark_ratio = mse_pkg::DOT_RATIO;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    lead_nxt    = lead_r;
    idx_nxt     = idx_r;
    phase_nxt   = phase_r;
    a_vld_nxt   = 1'b0;
    a_kind_nxt  = mse_pkg::KIND_SILENCE;
    a_last_nxt  = 1'b0;
    sel         = '0;
    job_pop     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          lead_nxt  = job.lead;
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (room) begin
          a_vld_nxt = 1'b1;
          if (job_r.is_space) begin
            sel        = d_word;
            a_last_nxt = 1'b1;
          end else if (lead_r) begin
            sel        = d_char;
            a_last_nxt = (job_r.nsym == '0);
            lead_nxt   = 1'b0;
          end else if (sym == mse_pkg::SYM_SPC) begin
            sel        = d_inner;
            a_last_nxt = last_sym;
            idx_nxt    = idx_r + 3'd1;
          end else if (!phase_r) begin
            a_kind_nxt = mse_pkg::KIND_MARK;
            sel        = {2'b00, mark_ratio};
            phase_nxt  = 1'b1;
          end else begin
            a_kind_nxt = mse_pkg::KIND_GAP;
            sel        = {2'b00, cfg.mark_gap_ratio};
            a_last_nxt = last_sym;
            phase_nxt  = 1'b0;
            idx_nxt    = idx_r + 3'd1;
          end
          if (a_last_nxt) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // negative ratios give zero length
    a_ratio_nxt = sel[mse_pkg::RATIO_W+1] ? '0 : sel[mse_pkg::RATIO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_vld_r <= a_vld_nxt;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    lead_r    <= lead_nxt;
    idx_r     <= idx_nxt;
    phase_r   <= phase_nxt;
    a_kind_r  <= a_kind_nxt;
    a_ratio_r <= a_ratio_nxt;
    a_last_r  <= a_last_nxt;
  end

  // 17x15 product over 256 never exceeds 24 bits
  assign prod = cfg.dot_samples * a_ratio_r;

  always_ff @(posedge clk) begin
    b_seg_r.kind    <= a_kind_r;
    b_seg_r.samples <= prod[mse_pkg::SAMPLES_W+7:8];
    b_seg_r.last    <= a_last_r;
  end

  assign seg_push = b_vld_r;
  assign seg      = b_seg_r;

endmodule
